@@ src/expiring_one_time_token_table_defines.svh @@
// Assertion macros shared by the token table checkers.
// No dependencies; include by bare file name inside a module body.
`ifndef EXPIRING_ONE_TIME_TOKEN_TABLE_DEFINES_SVH
`define EXPIRING_ONE_TIME_TOKEN_TABLE_DEFINES_SVH

// Clocked property, skipped while reset is high.
`define EOTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, also checked during reset.
`define EOTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/eott_pkg.sv @@
// Types and constants for the expiring one-time token table.
// No dependencies; imported by the RAM wrapper users, top level and checker.
package eott_pkg;

   localparam int TIME_W        = 32;
   localparam int TOKEN_W       = 256;
   localparam int SLOT_W        = 4;
   localparam int REQ_TDATA_W   = 288;
   localparam int REQ_TUSER_W   = 2;
   localparam int RSP_TDATA_W   = 8;
   localparam int RSP_TUSER_W   = 1;
   localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd30000;

   // bit positions inside the request word
   localparam int REQ_NOW_LSB   = 0;
   localparam int REQ_TOKEN_LSB = 32;
   localparam int REQ_OP_BIT    = 0;
   localparam int REQ_WF_BIT    = 1;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_CONSUME = 1'b1
   } opcode_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FAIL = 1'b1
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

@@ src/eott_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module eott_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/expiring_one_time_token_table.sv @@
// Expiring one-time token table: top level with scan control and live bits.
// Depends on eott_pkg and eott_ram (creation ticks and token memories).
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: now_ms, token words; tuser: opcode, key flag
//   rsp      out  rsp_tvalid/rsp_tready  tdata: slot; tuser: status
//   csr      in   csr_wr_en              csr_wr_data: expiry_ms
//
// The walk reads one slot per cycle through the single read port of the entry memories.
// A new request is taken once the finish step is done, even while the last result is held.
// Reset clears every live bit at once and loads the expiry with 30000; no clearing pass.
// A stalled result port holds the finish step until the output register frees up.
module expiring_one_time_token_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] now_ms, [95:32] token_word0, [159:96] token_word1,
   // [223:160] token_word2, [287:224] token_word3
   input  logic [eott_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] opcode, [1] key_well_formed
   input  logic [eott_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] slot, [7:4] zero
   output logic [eott_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] status
   output logic [eott_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [eott_pkg::TIME_W-1:0]        csr_wr_data
);

   import eott_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     hit_ff, hit_in;
   logic [TABLE_ENTRIES-1:0] live_ff, live_in;
   logic [TIME_W-1:0]    expiry_ff, expiry_in;
   opcode_type           op_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TOKEN_W-1:0]   token_ff;
   logic                 wf_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 scan_issue;
   logic                 finish_go;
   logic                 mem_we;
   logic [TIME_W-1:0]    cr_rdata;
   logic [TOKEN_W-1:0]   tok_rdata;
   logic                 ev_live;
   logic                 ev_stale;
   logic                 ev_match;
   logic [TIME_W-1:0]    ev_age;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // creation ticks and tokens, one row per slot
   eott_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_created_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (hit_ff),
      .wr_data (now_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (cr_rdata)
   );

   eott_ram #(
      .WIDTH (TOKEN_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_token_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (hit_ff),
      .wr_data (token_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (tok_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == SCAN_END && !ev_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      scan_issue = 1'b0;
      finish_go  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   scan_issue = (idx_ff != SCAN_END);
         ST_FINISH: finish_go  = out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign mem_we = finish_go && (op_ff == OP_INSERT) && found_ff;

   // evaluate the slot whose row arrived from the memories this cycle
   assign ev_live  = live_ff[ev_idx_ff];
   assign ev_age   = now_ff - cr_rdata;
   assign ev_stale = ev_age > expiry_ff;
   assign ev_match = wf_ff && (tok_rdata == token_ff);

   always_comb begin
      idx_in      = idx_ff;
      ev_valid_in = 1'b0;
      ev_idx_in   = ev_idx_ff;
      if (req_accept) begin
         idx_in = '0;
      end else if (scan_issue) begin
         ev_valid_in = 1'b1;
         ev_idx_in   = idx_ff[IDX_W-1:0];
         idx_in      = idx_ff + 1'b1;
      end
   end

   always_comb begin
      live_in  = live_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      if (req_accept) begin
         found_in = 1'b0;
      end
      if (ev_valid_ff) begin
         if (op_ff == OP_INSERT) begin
            // drop stale entries everywhere, remember the lowest free slot
            if (ev_live && ev_stale) begin
               live_in[ev_idx_ff] = 1'b0;
            end
            if (!found_ff && (!ev_live || ev_stale)) begin
               found_in = 1'b1;
               hit_in   = ev_idx_ff;
            end
         end else if (!found_ff && ev_live) begin
            // walk stops at the first live match
            if (ev_stale) begin
               live_in[ev_idx_ff] = 1'b0;
            end else if (ev_match) begin
               live_in[ev_idx_ff] = 1'b0;
               found_in           = 1'b1;
               hit_in             = ev_idx_ff;
            end
         end
      end
      if (mem_we) begin
         live_in[hit_ff] = 1'b1;
      end
   end

   assign expiry_in = csr_wr_en ? csr_wr_data : expiry_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         ev_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         live_ff      <= '0;
         expiry_ff    <= EXPIRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ev_valid_ff  <= ev_valid_in;
         found_ff     <= found_in;
         live_ff      <= live_in;
         expiry_ff    <= expiry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= ev_idx_in;
      hit_ff    <= hit_in;
      if (req_accept) begin
         op_ff    <= opcode_type'(req_tuser[REQ_OP_BIT]);
         wf_ff    <= req_tuser[REQ_WF_BIT];
         now_ff   <= req_tdata[REQ_NOW_LSB +: TIME_W];
         token_ff <= req_tdata[REQ_TOKEN_LSB +: TOKEN_W];
      end
      if (finish_go) begin
         rsp_status_ff <= found_ff ? STATUS_OK : STATUS_FAIL;
         rsp_slot_ff   <= found_ff ? SLOT_W'(hit_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_slot_ff);
   assign rsp_tuser  = RSP_TUSER_W'(rsp_status_ff);

endmodule

@@ src/eott_checker.sv @@
// Port-level checks for the expiring one-time token table, bound to the top level.
// Depends on eott_pkg and expiring_one_time_token_table_defines.svh.
module eott_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [eott_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [eott_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   import eott_pkg::*;

   `include "expiring_one_time_token_table_defines.svh"

   // a stalled result word holds
   `EOTT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed under stall")

   // a failed request reports slot zero
   `EOTT_ASSERT(a_fail_slot, clock, reset, rsp_tvalid && (rsp_tuser[0] == STATUS_FAIL) |-> rsp_tdata == '0, "failed result carries a nonzero slot")

   // one request in the table at a time
   `EOTT_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while a walk is under way")

   // reset empties the result register
   `EOTT_ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind expiring_one_time_token_table eott_checker u_eott_checker (.*);

@@ tb/expiring_one_time_token_table_tb.sv @@
// Self-checking testbench for the expiring one-time token table.
// Depends on eott_pkg and the expiring_one_time_token_table top level only.
// Directed rows, then random insert/consume traffic under several expiry values.
`timescale 1ns / 1ps

module expiring_one_time_token_table_tb;
   import eott_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 58;
   localparam logic [31:0] BASE_TICK = 32'hFFFF_FFF0;
   localparam logic [255:0] TOK_A =
      256'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210_A5A5_5A5A_C3C3_3C3C_0F1E_2D3C_4B5A_6978;
   localparam logic [255:0] TOK_B = ~TOK_A;

   typedef struct {
      opcode_type    op;
      logic [31:0]   now;
      logic [255:0]  token;
      logic          wf;
   } token_req_type;

   typedef struct {
      status_type    status;
      logic [3:0]    slot;
   } token_rsp_type;

   typedef struct {
      opcode_type    op;
      logic [31:0]   now;
      logic [255:0]  token;
      logic          wf;
      logic          known;
      status_type    status;
      logic [3:0]    slot;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [REQ_TUSER_W-1:0]   req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic [RSP_TUSER_W-1:0]   rsp_tuser;
   logic                     csr_wr_en = 1'b0;
   logic [TIME_W-1:0]        csr_wr_data = '0;

   // predicted table contents
   logic          pend_live    [ENTRIES] = '{default: 1'b0};
   logic [31:0]   pend_created [ENTRIES] = '{default: 32'd0};
   logic [255:0]  pend_token   [ENTRIES] = '{default: 256'd0};
   logic [31:0]   pend_expiry = EXPIRY_RESET;

   token_rsp_type rsp_due [$];
   logic [255:0]  issued_tokens [$];
   logic [31:0]   clock_ms = 32'd0;
   int            burst_left = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            n_stored = 0, n_full = 0, n_hits = 0, n_misses = 0;

   logic          hold_req = 1'b0;
   logic          hold_taken = 1'b0;
   int            hold_left = 0;
   logic [5:0]    stall_phase = '0;
   int            stall_mode = 0;

   dir_row_type directed_rows [25] = '{
      '{OP_INSERT,  32'd0,     TOK_A,            1'b0, 1'b1, STATUS_OK,   4'd0},
      // malformed key never matches
      '{OP_CONSUME, 32'd1,     TOK_A,            1'b0, 1'b1, STATUS_FAIL, 4'd0},
      '{OP_CONSUME, 32'd2,     TOK_A,            1'b1, 1'b1, STATUS_OK,   4'd0},
      // single use: second consume misses
      '{OP_CONSUME, 32'd3,     TOK_A,            1'b1, 1'b1, STATUS_FAIL, 4'd0},
      // fill the table just below the tick wrap
      '{OP_INSERT,  BASE_TICK, 256'd0,           1'b1, 1'b1, STATUS_OK,   4'd0},
      '{OP_INSERT,  BASE_TICK, '1,               1'b0, 1'b1, STATUS_OK,   4'd1},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd2,   1'b0, 1'b1, STATUS_OK,   4'd2},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd3,   1'b1, 1'b1, STATUS_OK,   4'd3},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd4,   1'b0, 1'b1, STATUS_OK,   4'd4},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd5,   1'b1, 1'b1, STATUS_OK,   4'd5},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd6,   1'b0, 1'b1, STATUS_OK,   4'd6},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd7,   1'b1, 1'b1, STATUS_OK,   4'd7},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd8,   1'b0, 1'b1, STATUS_OK,   4'd8},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd9,   1'b1, 1'b1, STATUS_OK,   4'd9},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd10,  1'b0, 1'b1, STATUS_OK,   4'd10},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd11,  1'b1, 1'b1, STATUS_OK,   4'd11},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd12,  1'b0, 1'b1, STATUS_OK,   4'd12},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd13,  1'b1, 1'b1, STATUS_OK,   4'd13},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd14,  1'b0, 1'b1, STATUS_OK,   4'd14},
      '{OP_INSERT,  BASE_TICK, TOK_A ^ 256'd15,  1'b1, 1'b1, STATUS_OK,   4'd15},
      // table full
      '{OP_INSERT,  BASE_TICK, TOK_B,            1'b1, 1'b1, STATUS_FAIL, 4'd0},
      // age wraps through zero, still live
      '{OP_CONSUME, 32'd5,     '1,               1'b1, 1'b1, STATUS_OK,   4'd1},
      // age equal to the expiry is not stale
      '{OP_CONSUME, 32'd29984, TOK_B,            1'b1, 1'b0, STATUS_FAIL, 4'd0},
      // one tick later every entry is stale
      '{OP_CONSUME, 32'd29985, TOK_A ^ 256'd2,   1'b1, 1'b1, STATUS_FAIL, 4'd0},
      '{OP_INSERT,  32'd29985, TOK_B,            1'b0, 1'b1, STATUS_OK,   4'd0}
   };

   expiring_one_time_token_table #(
      .TABLE_ENTRIES (ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Apply one request to the predicted table and return its response.
   function automatic token_rsp_type table_step(token_req_type w);
      token_rsp_type r;
      logic [31:0] age;
      r.status = STATUS_FAIL;
      r.slot   = 4'd0;
      if (w.op == OP_INSERT) begin
         for (int i = 0; i < ENTRIES; i++) begin
            age = w.now - pend_created[i];
            if (pend_live[i] && age > pend_expiry)
               pend_live[i] = 1'b0;
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!pend_live[i]) begin
               pend_token[i]   = w.token;
               pend_created[i] = w.now;
               pend_live[i]    = 1'b1;
               r.status = STATUS_OK;
               r.slot   = 4'(i);
               break;
            end
         end
         if (r.status == STATUS_OK) n_stored++;
         else n_full++;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            age = w.now - pend_created[i];
            if (!pend_live[i])
               continue;
            if (age > pend_expiry) begin
               pend_live[i] = 1'b0;
               continue;
            end
            if (w.wf && pend_token[i] == w.token) begin
               pend_live[i] = 1'b0;
               r.status = STATUS_OK;
               r.slot   = 4'(i);
               break;
            end
         end
         if (r.status == STATUS_OK) n_hits++;
         else n_misses++;
      end
      return r;
   endfunction

   function automatic logic [255:0] random_token();
      logic [255:0] t;
      for (int i = 0; i < 8; i++)
         t[i*32 +: 32] = $urandom;
      return t;
   endfunction

   // Advance the millisecond tick: mostly small steps, some near the expiry edge.
   function automatic logic [31:0] next_tick(logic [31:0] cur);
      int unsigned pick;
      logic [31:0] span;
      pick = $urandom_range(0, 99);
      span = (pend_expiry > 32'd2000) ? 32'd2000 : pend_expiry + 32'd2;
      if (pick < 40) return cur;
      if (pick < 85) return cur + $urandom_range(0, span);
      if (pick < 95) return cur + pend_expiry + $urandom_range(0, 1);
      return $urandom;
   endfunction

   function automatic token_req_type random_word(int insert_pct);
      token_req_type w;
      int unsigned pick;
      int n;
      clock_ms = next_tick(clock_ms);
      w.now = clock_ms;
      w.wf  = 1'($urandom_range(0, 1));
      n     = issued_tokens.size();
      pick  = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < insert_pct) begin
         w.op = OP_INSERT;
         // duplicates exercise the lowest-slot-first match on consume
         if (pick < 15 && n > 0)
            w.token = issued_tokens[$urandom_range(0, n - 1)];
         else
            w.token = random_token();
         issued_tokens.push_back(w.token);
         if (issued_tokens.size() > 24)
            void'(issued_tokens.pop_front());
      end else begin
         w.op = OP_CONSUME;
         w.wf = 1'b1;
         if (n == 0 || pick >= 85) begin
            w.token = random_token();
         end else begin
            w.token = issued_tokens[$urandom_range(0, n - 1)];
            if (pick < 10)
               w.wf = 1'b0;
            else if (pick < 20)
               w.token ^= 256'd1 << $urandom_range(0, 255);
         end
      end
      return w;
   endfunction

   // Offer one word in bursts with random gaps; return at the accepting edge.
   task automatic offer_word(token_req_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {w.token, w.now};
      req_tuser  <= {w.wf, w.op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_expiry(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pend_expiry = value;
   endtask

   // Receiver: rotating stall patterns plus one long hold-off on request.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_phase == 6'd0)
            stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 4) == 0);
            default: rsp_tready <= (stall_phase[2:0] != 3'd0);
         endcase
      end
   end

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      token_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: response word with nothing outstanding: status %0b slot %0d",
                     $time, rsp_tuser[0], rsp_tdata[3:0]);
            mismatches++;
         end else begin
            exp_rsp = rsp_due.pop_front();
            if (status_type'(rsp_tuser[0]) != exp_rsp.status) begin
               $display("%0t: status expected %s, actual %0b",
                        $time, exp_rsp.status.name(), rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tdata[3:0] !== exp_rsp.slot) begin
               $display("%0t: slot expected %0d, actual %0d",
                        $time, exp_rsp.slot, rsp_tdata[3:0]);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      token_req_type w;
      token_rsp_type predicted;
      token_rsp_type typed;
      logic [31:0]   expiry_plan [7];
      int            insert_pct [7];

      insert_pct  = '{75, 55, 50, 50, 60, 50, 45};
      expiry_plan = '{32'hFFFF_FFFF, 32'd0, 32'd40, 32'd300, 32'd5000, $urandom, 32'd30000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         w.op    = directed_rows[i].op;
         w.now   = directed_rows[i].now;
         w.token = directed_rows[i].token;
         w.wf    = directed_rows[i].wf;
         offer_word(w);
         predicted = table_step(w);
         if (directed_rows[i].known) begin
            typed.status = directed_rows[i].status;
            typed.slot   = directed_rows[i].slot;
            rsp_due.push_back(typed);
         end else begin
            rsp_due.push_back(predicted);
         end
      end
      clock_ms = 32'd29985;

      for (int p = 0; p < 7; p++) begin
         drain_results();
         write_expiry(expiry_plan[p]);
         // long receiver stall while the table fills
         if (p == 0)
            hold_req <= 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            w = random_word(insert_pct[p]);
            offer_word(w);
            rsp_due.push_back(table_step(w));
         end
      end

      drain_results();
      repeat (ENTRIES + 4) @(posedge clock);
      $display("Covered %0d requests: %0d stored, %0d rejected full, %0d consumed, %0d missed",
               n_stored + n_full + n_hits + n_misses, n_stored, n_full, n_hits, n_misses);
      $display("Expiry ran at reset value, all ones, zero, small, medium and random settings");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
